// ===== hdl/tsas_pkg.sv =====
// ============================================================================
// Touch sample average/scale package
// Shared types, constants and helpers for the touch coordinate pipeline.
// ============================================================================
`default_nettype none

package tsas_pkg;

    // Field widths
    localparam int ADC_W     = 10;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 2;
    localparam int XPOS_W    = 9;
    localparam int YPOS_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;

    // Default parameter values
    localparam int X_SIZE_DEF      = 320;
    localparam int Y_SIZE_DEF      = 240;
    localparam int AVG_SAMPLES_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Calibration bound reset values
    localparam logic [ADC_W-1:0] BOUND_A_RST = 10'd30;
    localparam logic [ADC_W-1:0] BOUND_B_RST = 10'd220;

    // Division by three through a reciprocal: floor(s * 2731 / 8192) is exact
    // for every sum of three 10-bit samples.
    localparam int AVG3_RECIP = 2731;
    localparam int AVG3_SHIFT = 13;
    localparam int AVG3_PW    = SUM_W + 13;

    // Input item kinds
    localparam logic KIND_PEN_UP = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_BOUND_A,
        CFG_X_BOUND_B,
        CFG_Y_BOUND_A,
        CFG_Y_BOUND_B
    } tsas_cfg_idx_t;

    // Calibration bounds as seen by both halves of the pipeline
    typedef struct packed {
        logic [ADC_W-1:0] x_a;
        logic [ADC_W-1:0] x_b;
        logic [ADC_W-1:0] y_a;
        logic [ADC_W-1:0] y_b;
    } tsas_bounds_t;

    // One classified job handed from the front end to the scaler
    typedef struct packed {
        logic             touched;
        logic [ADC_W-1:0] ax;
        logic [ADC_W-1:0] ay;
    } tsas_job_t;

    // Scaler sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN,
        BK_OUT
    } tsas_back_state_t;

    // Truncating average of a sum of n samples, n from 1 to 3.
    function automatic logic [ADC_W-1:0] avg_of(input logic [SUM_W-1:0] s, input int n);
        logic [AVG3_PW-1:0] p;
        logic [ADC_W-1:0]   r;
        p = AVG3_PW'(s) * AVG3_PW'(AVG3_RECIP);
        case (n)
            1:       r = s[ADC_W-1:0];
            2:       r = s[ADC_W:1];
            default: r = p[AVG3_SHIFT +: ADC_W];
        endcase
        return r;
    endfunction

    // Inclusive window check against sorted bounds.
    function automatic logic in_window(input logic [ADC_W-1:0] v,
                                       input logic [ADC_W-1:0] a,
                                       input logic [ADC_W-1:0] b);
        logic [ADC_W-1:0] lo;
        logic [ADC_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/touch_sample_average_scale_top.sv =====
// ============================================================================
// Touch sample average and scale, top level
// Averages resistive-touch ADC pairs and scales them to screen coordinates.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid/in_stall    kind, x_sample, y_sample
//   result    out        out_valid/out_stall  touched, x_pos, y_pos
//   config    in         cfg_we               cfg_index, cfg_wdata
//
// A conversion pair that does not complete a set only updates the accumulators.
// A touched result is scaled by the bit-serial divider, run once per axis over
// PROD_W = 10 + clog2(max(X_SIZE, Y_SIZE)) quotient bits; an untouched result
// skips the divider and goes straight to the output register.
// The job queue holds QUEUE_DEPTH jobs; in_stall rises only when it is full.
// Reset is asynchronous and active low and restores the default bounds.
// ============================================================================
`default_nettype none

module touch_sample_average_scale_top #(
    parameter int X_SIZE      = tsas_pkg::X_SIZE_DEF,
    parameter int Y_SIZE      = tsas_pkg::Y_SIZE_DEF,
    parameter int AVG_SAMPLES = tsas_pkg::AVG_SAMPLES_DEF,
    parameter int QUEUE_DEPTH = tsas_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           kind,
    input  wire logic [tsas_pkg::ADC_W-1:0]     x_sample,
    input  wire logic [tsas_pkg::ADC_W-1:0]     y_sample,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                touched,
    output logic [tsas_pkg::XPOS_W-1:0]         x_pos,
    output logic [tsas_pkg::YPOS_W-1:0]         y_pos,
    input  wire logic                           cfg_we,
    input  wire logic [tsas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsas_pkg::CFG_W-1:0]     cfg_wdata
);
    import tsas_pkg::*;

    tsas_bounds_t bounds_reg, bounds_next;
    logic         q_full;
    logic         q_push;
    tsas_job_t    q_job;
    logic         q_pop;
    logic         head_valid;
    tsas_job_t    head_job;

    // Calibration register write decode.
    always_comb
    begin
        bounds_next = bounds_reg;
        if (cfg_we)
        begin
            case (tsas_cfg_idx_t'(cfg_index))
                CFG_X_BOUND_A: bounds_next.x_a = cfg_wdata[ADC_W-1:0];
                CFG_X_BOUND_B: bounds_next.x_b = cfg_wdata[ADC_W-1:0];
                CFG_Y_BOUND_A: bounds_next.y_a = cfg_wdata[ADC_W-1:0];
                CFG_Y_BOUND_B: bounds_next.y_b = cfg_wdata[ADC_W-1:0];
                default:       bounds_next = bounds_reg;
            endcase
        end
    end

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.x_a <= BOUND_A_RST;
            bounds_reg.x_b <= BOUND_B_RST;
            bounds_reg.y_a <= BOUND_A_RST;
            bounds_reg.y_b <= BOUND_B_RST;
        end
        else
        begin
            bounds_reg <= bounds_next;
        end
    end

    // Front end: accumulate, average and classify.
    tsas_front #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .x_sample (x_sample),
        .y_sample (y_sample),
        .bounds   (bounds_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    // Job queue between the two halves.
    tsas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Scaler and result register.
    tsas_back #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bounds     (bounds_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .touched    (touched),
        .x_pos      (x_pos),
        .y_pos      (y_pos)
    );

endmodule

`default_nettype wire

// ===== hdl/tsas_front.sv =====
// ============================================================================
// Touch sample front end
// Accepts input transactions, accumulates conversion pairs, averages them and
// classifies each completed set or pen-up event as a job for the scaler.
// ============================================================================
`default_nettype none

module tsas_front #(
    parameter int AVG_SAMPLES = tsas_pkg::AVG_SAMPLES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       kind,
    input  wire logic [tsas_pkg::ADC_W-1:0] x_sample,
    input  wire logic [tsas_pkg::ADC_W-1:0] y_sample,
    input  wire tsas_pkg::tsas_bounds_t     bounds,
    input  wire logic                       q_full,
    output logic                            q_push,
    output tsas_pkg::tsas_job_t             q_job
);
    import tsas_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;

    logic             accept;
    logic [CNT_W-1:0] count_inc;
    logic [SUM_W-1:0] sx_new;
    logic [SUM_W-1:0] sy_new;
    logic             set_done;
    logic [ADC_W-1:0] ax;
    logic [ADC_W-1:0] ay;
    logic             pos_ok;

    // The queue must have room before a transaction is taken.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Accumulate and average the current set.
    assign count_inc = count_reg + CNT_W'(1);
    assign sx_new    = sum_x_reg + SUM_W'(x_sample);
    assign sy_new    = sum_y_reg + SUM_W'(y_sample);
    assign set_done  = (count_inc == CNT_W'(AVG_SAMPLES));
    assign ax        = avg_of(sx_new, AVG_SAMPLES);
    assign ay        = avg_of(sy_new, AVG_SAMPLES);

    // A position is usable only inside both windows and with distinct bounds.
    assign pos_ok = in_window(ax, bounds.x_a, bounds.x_b)
                 && in_window(ay, bounds.y_a, bounds.y_b)
                 && (bounds.x_a != bounds.x_b)
                 && (bounds.y_a != bounds.y_b);

    // Accumulator update and job classification.
    always_comb
    begin
        count_next = count_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        q_push     = 1'b0;
        q_job      = '0;
        if (accept)
        begin
            if (kind == KIND_PEN_UP)
            begin
                count_next = '0;
                sum_x_next = '0;
                sum_y_next = '0;
                q_push     = 1'b1;
            end
            else if (set_done)
            begin
                count_next    = '0;
                sum_x_next    = '0;
                sum_y_next    = '0;
                q_push        = 1'b1;
                q_job.touched = pos_ok;
                q_job.ax      = ax;
                q_job.ay      = ay;
            end
            else
            begin
                count_next = count_inc;
                sum_x_next = sx_new;
                sum_y_next = sy_new;
            end
        end
    end

    // Accumulator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    // The sample count never reaches a full set while it is held.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(AVG_SAMPLES))
        else $error("tsas_front: sample count reached a full set");

endmodule

`default_nettype wire

// ===== hdl/tsas_queue.sv =====
// ============================================================================
// Touch job queue
// Short FIFO that decouples the front end from the scaler.
// ============================================================================
`default_nettype none

module tsas_queue #(
    parameter int DEPTH = tsas_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tsas_pkg::tsas_job_t push_job,
    input  wire logic                pop,
    output logic                     full,
    output logic                     head_valid,
    output tsas_pkg::tsas_job_t      head_job
);
    import tsas_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    tsas_job_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (fill_reg == FILL_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The front end never offers a job to a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("tsas_queue: push into a full queue");

endmodule

`default_nettype wire

// ===== hdl/tsas_back.sv =====
// ============================================================================
// Touch coordinate scaler
// Takes jobs from the queue, scales each axis with one multiply and a shared
// bit-serial signed divider, and holds the result in an output register.
// ============================================================================
`default_nettype none

module tsas_back #(
    parameter int X_SIZE = tsas_pkg::X_SIZE_DEF,
    parameter int Y_SIZE = tsas_pkg::Y_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tsas_pkg::tsas_bounds_t      bounds,
    input  wire logic                        head_valid,
    input  wire tsas_pkg::tsas_job_t         head_job,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             touched,
    output logic [tsas_pkg::XPOS_W-1:0]      x_pos,
    output logic [tsas_pkg::YPOS_W-1:0]      y_pos
);
    import tsas_pkg::*;

    localparam int SZ_MAX = (X_SIZE > Y_SIZE) ? X_SIZE : Y_SIZE;
    localparam int SZ_W   = $clog2(SZ_MAX);
    localparam int PROD_W = ADC_W + SZ_W;
    localparam int DC_W   = $clog2(PROD_W + 1);
    localparam int REM_W  = ADC_W + 1;

    // Sequencer control
    tsas_back_state_t state_reg, state_next;
    logic             axis_reg, axis_next;
    logic             out_valid_reg, out_valid_next;
    logic [DC_W-1:0]  dcnt_reg, dcnt_next;

    // Datapath
    tsas_job_t         job_reg, job_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ADC_W-1:0]  dmag_reg, dmag_next;
    logic              neg_reg, neg_next;
    logic [XPOS_W-1:0] xp_reg, xp_next;
    logic [YPOS_W-1:0] yp_reg, yp_next;
    logic              touched_reg, touched_next;
    logic [XPOS_W-1:0] x_pos_reg, x_pos_next;
    logic [YPOS_W-1:0] y_pos_reg, y_pos_next;

    // Per-axis operand selection
    logic [ADC_W-1:0]  avg_sel;
    logic [ADC_W-1:0]  a_sel;
    logic [ADC_W-1:0]  b_sel;
    logic [SZ_W-1:0]   size_m1;
    logic [PROD_W-1:0] size_full;
    logic [ADC_W:0]    diff;
    logic [ADC_W:0]    diff_abs;
    logic [ADC_W:0]    den;
    logic [ADC_W:0]    den_abs;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  rem_sh;
    logic              ge;
    logic [PROD_W-1:0] q_signed;
    logic [PROD_W-1:0] pos_full;
    logic              out_load;

    assign avg_sel   = axis_reg ? job_reg.ay : job_reg.ax;
    assign a_sel     = axis_reg ? bounds.y_a : bounds.x_a;
    assign b_sel     = axis_reg ? bounds.y_b : bounds.x_b;
    assign size_m1   = axis_reg ? SZ_W'(Y_SIZE - 1) : SZ_W'(X_SIZE - 1);
    assign size_full = axis_reg ? PROD_W'(Y_SIZE) : PROD_W'(X_SIZE);

    // Numerator magnitude and sign, denominator magnitude and sign.
    assign diff     = {1'b0, avg_sel} - {1'b0, a_sel};
    assign diff_abs = diff[ADC_W] ? (~diff + (ADC_W+1)'(1)) : diff;
    assign den      = {1'b0, b_sel} - {1'b0, a_sel};
    assign den_abs  = den[ADC_W] ? (~den + (ADC_W+1)'(1)) : den;
    assign prod     = PROD_W'(diff_abs[ADC_W-1:0]) * PROD_W'(size_m1);

    // One restoring division step.
    assign rem_sh = {rem_reg[REM_W-2:0], quo_reg[PROD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dmag_reg});

    // Signed quotient and position, kept modulo the output width.
    assign q_signed = neg_reg ? (~quo_reg + PROD_W'(1)) : quo_reg;
    assign pos_full = size_full - q_signed;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        dcnt_next  = dcnt_reg;
        job_next   = job_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        xp_next    = xp_reg;
        yp_next    = yp_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    q_pop     = 1'b1;
                    job_next  = head_job;
                    axis_next = 1'b0;
                    state_next = head_job.touched ? BK_MUL : BK_OUT;
                end
            end
            BK_MUL:
            begin
                quo_next   = prod;
                rem_next   = '0;
                dmag_next  = den_abs[ADC_W-1:0];
                neg_next   = diff[ADC_W] ^ den[ADC_W];
                dcnt_next  = DC_W'(PROD_W);
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                rem_next  = ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
                quo_next  = {quo_reg[PROD_W-2:0], ge};
                dcnt_next = dcnt_reg - DC_W'(1);
                if (dcnt_reg == DC_W'(1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (!axis_reg)
                begin
                    xp_next    = pos_full[XPOS_W-1:0];
                    axis_next  = 1'b1;
                    state_next = BK_MUL;
                end
                else
                begin
                    yp_next    = pos_full[YPOS_W-1:0];
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Output register: loaded by the sequencer, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        touched_next   = touched_reg;
        x_pos_next     = x_pos_reg;
        y_pos_next     = y_pos_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            touched_next   = job_reg.touched;
            x_pos_next     = job_reg.touched ? xp_reg : '0;
            y_pos_next     = job_reg.touched ? yp_reg : '0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            axis_reg      <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dmag_reg    <= dmag_next;
        neg_reg     <= neg_next;
        xp_reg      <= xp_next;
        yp_reg      <= yp_next;
        touched_reg <= touched_next;
        x_pos_reg   <= x_pos_next;
        y_pos_reg   <= y_pos_next;
    end

    assign out_valid = out_valid_reg;
    assign touched   = touched_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;

    // A touched job had distinct bounds; later writes can zero the divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (dmag_reg != '0))
        else $error("tsas_back: division by zero");

    // An untouched result reports the origin.
    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !touched) |-> (x_pos == '0 && y_pos == '0))
        else $error("tsas_back: untouched result with nonzero position");

endmodule

`default_nettype wire
